>>> hdl/scc_pkg.sv
// Shared types and constants for the segment crossing counter.
package scc_pkg;

    localparam int SIDE_CODE_W = 3;
    localparam int OFFSET_W    = 6;
    localparam int PAIRS_W     = 11;
    localparam int MOST_W      = 6;

    localparam logic [SIDE_CODE_W-1:0] SIDE_TOP    = 3'd1;
    localparam logic [SIDE_CODE_W-1:0] SIDE_BOTTOM = 3'd2;
    localparam logic [SIDE_CODE_W-1:0] SIDE_LEFT   = 3'd3;
    localparam logic [SIDE_CODE_W-1:0] SIDE_RIGHT  = 3'd4;

    typedef struct packed {
        logic [SIDE_CODE_W-1:0] start_side;
        logic [OFFSET_W-1:0]    start_offset;
        logic [SIDE_CODE_W-1:0] end_side;
        logic [OFFSET_W-1:0]    end_offset;
        logic                   last_segment;
    } t_in_word;

    typedef struct packed {
        logic [PAIRS_W-1:0] crossing_pairs;
        logic [MOST_W-1:0]  most_crossings;
        logic               overflow;
    } t_out_word;

    // one stored chord, as raw side/offset pairs
    typedef struct packed {
        logic [SIDE_CODE_W-1:0] start_side;
        logic [OFFSET_W-1:0]    start_offset;
        logic [SIDE_CODE_W-1:0] end_side;
        logic [OFFSET_W-1:0]    end_offset;
    } t_seg;

    // travels with each read of the partner chord
    typedef struct packed {
        logic valid;
        logic self_pair;
        logic row_last;
    } t_tag;

    // pair test outcome back to the controller
    typedef struct packed {
        logic valid;
        logic row_last;
        logic hit;
    } t_res;

endpackage

>>> hdl/segment_crossing_counter_top.sv
// Segment crossing counter: chord store in RAM plus pairwise crossing walk.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one chord per word.
// While loading, one word is taken every cycle and written to the chord RAM.
// Chords beyond MAX_SEGMENTS are dropped and flagged in the result.
// The word marked last_segment closes the set and starts the pairwise walk;
// o_in_ready stays low until the walk finishes.
// The walk reads each chord i once, then streams every chord j through the
// crossing pipeline, one RAM read per cycle.
// The result word (o_out_valid / i_out_ready / o_out_data) sits in an output
// register; loading of the next set goes on while it waits. A stalled
// receiver only holds the block at the end of the next walk.
// Reset empties the store count and drop flag and drops any pending result;
// the chord RAM is not cleared, since only written entries are ever read.
module segment_crossing_counter_top #(
    parameter int MAX_SEGMENTS = 64,
    parameter int SIDE         = 51
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  scc_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scc_pkg::t_out_word o_out_data
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_A,
        S_GET_A,
        S_SCAN,
        S_DRAIN,
        S_FINAL
    } t_state;

    t_state r_state, n_state;
    logic [NW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [IW-1:0] r_i, n_i, r_j, n_j;
    logic [IW-1:0] r_cnt, n_cnt, r_best, n_best;
    logic [TW-1:0] r_total, n_total;
    logic          r_out_valid, n_out_valid;
    scc_pkg::t_out_word r_out_data, n_out_data;
    scc_pkg::t_tag r_rd_tag, n_rd_tag;

    logic          w_in_acc;
    logic          w_we;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_last_idx;
    logic [IW-1:0] w_row_cnt;
    logic          w_load_a;
    scc_pkg::t_seg w_wseg, w_rseg;
    scc_pkg::t_res w_res;
    logic [TW+scc_pkg::PAIRS_W-1:0] w_tot_ext, w_half;
    logic [IW+scc_pkg::MOST_W-1:0]  w_best_ext;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last_idx = IW'(r_count - NW'(1));

    assign w_wseg.start_side   = i_in_data.start_side;
    assign w_wseg.start_offset = i_in_data.start_offset;
    assign w_wseg.end_side     = i_in_data.end_side;
    assign w_wseg.end_offset   = i_in_data.end_offset;

    scc_ram #(
        .WIDTH ($bits(scc_pkg::t_seg)),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_wseg),
        .i_raddr (w_raddr),
        .o_rdata (w_rseg)
    );

    scc_cross #(
        .SIDE (SIDE)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load_a (w_load_a),
        .i_seg    (w_rseg),
        .i_tag    (r_rd_tag),
        .o_res    (w_res)
    );

    assign w_tot_ext  = {{scc_pkg::PAIRS_W{1'b0}}, r_total};
    assign w_half     = w_tot_ext >> 1;
    assign w_best_ext = {{scc_pkg::MOST_W{1'b0}}, r_best};
    assign w_row_cnt  = r_cnt + IW'(w_res.hit);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_rd_tag    = '0;
        w_we        = 1'b0;
        w_raddr     = r_j;
        w_load_a    = 1'b0;

        // per-row tally from the pipeline
        if (w_res.valid) begin
            n_total = r_total + TW'(w_res.hit);
            if (w_res.row_last) begin
                n_cnt = '0;
                if (w_row_cnt > r_best) begin
                    n_best = w_row_cnt;
                end
            end else begin
                n_cnt = w_row_cnt;
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (r_count < NW'(MAX_SEGMENTS)) begin
                        w_we    = 1'b1;
                        n_count = r_count + NW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_data.last_segment) begin
                        n_state = S_RD_A;
                        n_i     = '0;
                        n_cnt   = '0;
                        n_best  = '0;
                        n_total = '0;
                    end
                end
            end
            S_RD_A: begin
                w_raddr = r_i;
                n_state = S_GET_A;
            end
            S_GET_A: begin
                w_load_a = 1'b1;
                n_j      = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                w_raddr            = r_j;
                n_rd_tag.valid     = 1'b1;
                n_rd_tag.self_pair = (r_j == r_i);
                n_rd_tag.row_last  = (r_j == w_last_idx);
                n_j                = r_j + IW'(1);
                if (r_j == w_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_res.valid && w_res.row_last) begin
                    if (r_i == w_last_idx) begin
                        n_state = S_FINAL;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = S_RD_A;
                    end
                end
            end
            S_FINAL: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_data.crossing_pairs  = w_half[scc_pkg::PAIRS_W-1:0];
                    n_out_data.most_crossings  = w_best_ext[scc_pkg::MOST_W-1:0];
                    n_out_data.overflow        = r_drop;
                    n_count                    = '0;
                    n_drop                     = 1'b0;
                    n_state                    = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_best      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_rd_tag    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_i         <= n_i;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_best      <= n_best;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_rd_tag    <= n_rd_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // pipeline is empty whenever new chords are being loaded
    a_drained_in_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !w_res.valid
    ) else $error("pair pipeline busy while loading");

    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_SEGMENTS)
    ) else $error("segment count beyond capacity");

    a_walk_nonempty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0)
    ) else $error("walk started on empty store");

    a_result_from_final: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINAL)
    ) else $error("result raised outside final step");

endmodule

>>> hdl/scc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/scc_cross.sv
// Pipelined crossing test of one held chord against a stream of partner chords.
module scc_cross #(
    parameter int SIDE = 51
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load_a,
    input  scc_pkg::t_seg i_seg,
    input  scc_pkg::t_tag i_tag,
    output scc_pkg::t_res o_res
);

    localparam int MAGW = ($clog2(SIDE + 1) > scc_pkg::OFFSET_W) ?
                          $clog2(SIDE + 1) : scc_pkg::OFFSET_W;
    localparam int PW = MAGW + 1;   // signed coordinate
    localparam int DW = PW + 1;     // coordinate difference
    localparam int MW = 2 * DW;     // product
    localparam int VW = MW + 1;     // cross product

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } t_pt;

    function automatic t_pt map_pt(input logic [scc_pkg::SIDE_CODE_W-1:0] code,
                                   input logic [scc_pkg::OFFSET_W-1:0] off);
        t_pt p;
        logic signed [PW-1:0] d;
        logic signed [PW-1:0] s;
        d = $signed({{(PW - scc_pkg::OFFSET_W){1'b0}}, off});
        s = $signed(PW'(SIDE));
        p = '0;
        unique case (code)
            scc_pkg::SIDE_TOP: begin
                p.x = d;
                p.y = s;
            end
            scc_pkg::SIDE_BOTTOM: begin
                p.x = d;
            end
            scc_pkg::SIDE_LEFT: begin
                p.y = s - d;
            end
            scc_pkg::SIDE_RIGHT: begin
                p.x = s;
                p.y = s - d;
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    // lexicographic a <= b, x first
    function automatic logic pt_le(input t_pt a, input t_pt b);
        return (a.x == b.x) ? (a.y <= b.y) : (a.x <= b.x);
    endfunction

    t_pt w_p0, w_p1, w_blo, w_bhi;
    logic w_col;

    t_pt r_a0, r_a1, r_alo, r_ahi;
    logic signed [DW-1:0] r_dax, r_day;

    scc_pkg::t_tag r_p1_tag, r_p2_tag;
    logic signed [DW-1:0] r_p1_dbx, r_p1_dby;
    logic signed [DW-1:0] r_p1_e1x, r_p1_e1y, r_p1_e2x, r_p1_e2y;
    logic signed [DW-1:0] r_p1_e3x, r_p1_e3y, r_p1_e4x, r_p1_e4y;
    logic r_p1_col, r_p2_col;

    logic signed [MW-1:0] r_m1a, r_m1b, r_m2a, r_m2b, r_m3a, r_m3b, r_m4a, r_m4b;
    logic signed [VW-1:0] w_v1, w_v2, w_v3, w_v4;
    logic w_pos1, w_pos2, w_pos3, w_pos4;
    logic w_neg1, w_neg2, w_neg3, w_neg4;
    logic w_hit;
    scc_pkg::t_res r_res;

    assign w_p0 = map_pt(i_seg.start_side, i_seg.start_offset);
    assign w_p1 = map_pt(i_seg.end_side, i_seg.end_offset);

    // collinear case: spans must overlap without either containing the other
    always_comb begin
        if (pt_le(w_p1, w_p0)) begin
            w_blo = w_p1;
            w_bhi = w_p0;
        end else begin
            w_blo = w_p0;
            w_bhi = w_p1;
        end
        w_col = pt_le(r_alo, w_bhi) && pt_le(w_blo, r_ahi) &&
                !((pt_le(r_alo, w_blo) && pt_le(w_bhi, r_ahi)) ||
                  (pt_le(w_blo, r_alo) && pt_le(r_ahi, w_bhi)));
    end

    always_ff @(posedge i_clk) begin
        if (i_load_a) begin
            r_a0  <= w_p0;
            r_a1  <= w_p1;
            r_dax <= DW'(w_p1.x) - DW'(w_p0.x);
            r_day <= DW'(w_p1.y) - DW'(w_p0.y);
            if (pt_le(w_p1, w_p0)) begin
                r_alo <= w_p1;
                r_ahi <= w_p0;
            end else begin
                r_alo <= w_p0;
                r_ahi <= w_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tag <= '0;
            r_p2_tag <= '0;
            r_res    <= '0;
        end else begin
            r_p1_tag     <= i_tag;
            r_p2_tag     <= r_p1_tag;
            r_res.valid    <= r_p2_tag.valid;
            r_res.row_last <= r_p2_tag.row_last;
            r_res.hit      <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_dbx <= DW'(w_p1.x) - DW'(w_p0.x);
        r_p1_dby <= DW'(w_p1.y) - DW'(w_p0.y);
        r_p1_e1x <= DW'(w_p0.x) - DW'(r_a1.x);
        r_p1_e1y <= DW'(w_p0.y) - DW'(r_a1.y);
        r_p1_e2x <= DW'(w_p1.x) - DW'(r_a1.x);
        r_p1_e2y <= DW'(w_p1.y) - DW'(r_a1.y);
        r_p1_e3x <= DW'(r_a0.x) - DW'(w_p1.x);
        r_p1_e3y <= DW'(r_a0.y) - DW'(w_p1.y);
        r_p1_e4x <= DW'(r_a1.x) - DW'(w_p1.x);
        r_p1_e4y <= DW'(r_a1.y) - DW'(w_p1.y);
        r_p1_col <= w_col;

        r_m1a <= r_dax * r_p1_e1y;
        r_m1b <= r_day * r_p1_e1x;
        r_m2a <= r_dax * r_p1_e2y;
        r_m2b <= r_day * r_p1_e2x;
        r_m3a <= r_p1_dbx * r_p1_e3y;
        r_m3b <= r_p1_dby * r_p1_e3x;
        r_m4a <= r_p1_dbx * r_p1_e4y;
        r_m4b <= r_p1_dby * r_p1_e4x;
        r_p2_col <= r_p1_col;
    end

    always_comb begin
        w_v1 = VW'(r_m1a) - VW'(r_m1b);
        w_v2 = VW'(r_m2a) - VW'(r_m2b);
        w_v3 = VW'(r_m3a) - VW'(r_m3b);
        w_v4 = VW'(r_m4a) - VW'(r_m4b);
        w_neg1 = w_v1[VW-1];
        w_neg2 = w_v2[VW-1];
        w_neg3 = w_v3[VW-1];
        w_neg4 = w_v4[VW-1];
        w_pos1 = !w_neg1 && (w_v1 != '0);
        w_pos2 = !w_neg2 && (w_v2 != '0);
        w_pos3 = !w_neg3 && (w_v3 != '0);
        w_pos4 = !w_neg4 && (w_v4 != '0);
        // reject when either chord has both ends strictly on one side of the other
        w_hit = !r_p2_tag.self_pair &&
                !((w_pos1 && w_pos2) || (w_neg1 && w_neg2) ||
                  (w_pos3 && w_pos4) || (w_neg3 && w_neg4)) &&
                (w_pos1 || w_neg1 || w_pos2 || w_neg2 ||
                 w_pos3 || w_neg3 || w_pos4 || w_neg4 || r_p2_col);
    end

    assign o_res = r_res;

endmodule
